@@ src/dvr_pkg.sv @@
`timescale 1ns / 1ps
// distance-vector route update: shared types, sizes and status codes
// used by dvr_cell and distance_vector_route_update; no dependencies
package dvr_pkg;

	localparam int TABLE_SIZE = 32;
	localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
	localparam int SLOT_W     = 5;
	localparam int ADDR_W     = 32;
	localparam int COST_W     = 8;

	localparam logic [1:0] ST_INSERTED = 2'd0;
	localparam logic [1:0] ST_IMPROVED = 2'd1;
	localparam logic [1:0] ST_KEPT     = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	localparam logic [COST_W-1:0] COST_ONE = COST_W'(1);
	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef struct packed {
		logic [ADDR_W-1:0] neighbor_addr;
		logic [ADDR_W-1:0] receive_interface;
		logic [ADDR_W-1:0] advertised_dest;
		logic [COST_W-1:0] advertised_cost;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] slot;
		logic [COST_W-1:0] stored_cost;
		logic [ADDR_W-1:0] stored_next_hop;
	} rsp_t;

	// request as broadcast to every cell
	typedef struct packed {
		logic [ADDR_W-1:0] dest;
		logic [ADDR_W-1:0] next_hop;
		logic [ADDR_W-1:0] intf;
		logic [COST_W-1:0] cand;
	} route_t;

	// scan token handed from cell to cell
	typedef struct packed {
		logic              active;
		logic              found;
		logic              have_free;
		logic [IDX_W-1:0]  free_slot;
		logic [1:0]        status;
		logic [IDX_W-1:0]  slot;
		logic [COST_W-1:0] cost;
		logic [ADDR_W-1:0] hop;
	} tok_t;

	// insert command into one free cell
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] slot;
	} ins_t;

	function automatic logic [SLOT_W-1:0] slot_of(logic [IDX_W-1:0] i);
		logic [IDX_W+SLOT_W-1:0] w;
		w = {{SLOT_W{1'b0}}, i};
		return w[SLOT_W-1:0];
	endfunction

endpackage

@@ src/distance_vector_route_update.sv @@
`timescale 1ns / 1ps
// distance-vector route update: routing table as a chain of entry cells
// depends on dvr_pkg and dvr_cell
//
//  channel | signals                      | direction
//  request | req_valid, req_stall, req    | in
//  result  | rsp_valid, rsp_stall, rsp    | out
//
// a request walks the chain one cell per cycle; it is registered in launch_q,
// in each cell's token register and in done_tok_q, then in the output register;
// the next request is taken only once the finished walk has moved to the output
// register; reset clears every entry's valid bit at once
// a stalled result holds in the output register, a finished walk in done_tok_q
module distance_vector_route_update (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  dvr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output dvr_pkg::rsp_t rsp
);
	import dvr_pkg::*;

	logic   busy_q;
	logic   launch_q;
	logic   done_q;
	tok_t   done_tok_q;
	route_t route_q;
	logic   rsp_valid_q;
	rsp_t   rsp_q;

	logic              accept;
	logic              fire;
	logic [COST_W-1:0] cand;
	route_t            route_d;
	ins_t              ins;
	rsp_t              rsp_d;
	tok_t              tok [TABLE_SIZE+1];
	logic [TABLE_SIZE:0] tok_act;

	assign accept    = req_valid && !req_stall;
	assign req_stall = busy_q;
	assign fire      = done_q && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (req.neighbor_addr == req.advertised_dest) begin
			cand = COST_ONE;
		end else if (req.advertised_cost == COST_MAX) begin
			cand = COST_MAX;
		end else begin
			cand = req.advertised_cost + COST_ONE;
		end
		route_d.dest     = req.advertised_dest;
		route_d.next_hop = req.neighbor_addr;
		route_d.intf     = req.receive_interface;
		route_d.cand     = cand;
	end

	always_comb begin
		tok[0]        = '0;
		tok[0].active = launch_q;
	end

	genvar g;
	generate
		for (g = 0; g < TABLE_SIZE; g++) begin : g_cell
			dvr_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IDX_W'(g)),
				.route   (route_q),
				.ins     (ins),
				.tok_in  (tok[g]),
				.tok_out (tok[g+1])
			);
		end
		for (g = 0; g <= TABLE_SIZE; g++) begin : g_act
			assign tok_act[g] = tok[g].active;
		end
	endgenerate

	// end of walk: found entry, insert into free cell, or drop
	always_comb begin
		ins.en   = 1'b0;
		ins.slot = done_tok_q.free_slot;
		if (done_tok_q.found) begin
			rsp_d.status          = done_tok_q.status;
			rsp_d.slot            = slot_of(done_tok_q.slot);
			rsp_d.stored_cost     = done_tok_q.cost;
			rsp_d.stored_next_hop = done_tok_q.hop;
		end else if (done_tok_q.have_free) begin
			rsp_d.status          = ST_INSERTED;
			rsp_d.slot            = slot_of(done_tok_q.free_slot);
			rsp_d.stored_cost     = route_q.cand;
			rsp_d.stored_next_hop = route_q.next_hop;
			ins.en                = fire;
		end else begin
			rsp_d = '0;
			rsp_d.status = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			launch_q    <= 1'b0;
			done_q      <= 1'b0;
			done_tok_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			launch_q <= accept;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fire) begin
				busy_q <= 1'b0;
			end
			if (tok[TABLE_SIZE].active) begin
				done_q     <= 1'b1;
				done_tok_q <= tok[TABLE_SIZE];
			end else if (fire) begin
				done_q <= 1'b0;
			end
			if (fire) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			route_q <= route_d;
		end
		if (fire) begin
			rsp_q <= rsp_d;
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_act) <= 1)
		else $error("more than one scan token in the chain");

	a_walk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_SIZE].active |-> busy_q && !done_q)
		else $error("walk finished with no request in flight");

	a_fire_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q && !busy_q)
		else $error("finished request not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		launch_q |-> busy_q && !done_q)
		else $error("walk launched while not busy");

endmodule

@@ src/dvr_cell.sv @@
`timescale 1ns / 1ps
// distance-vector route update: one routing table entry as a chain cell
// depends on dvr_pkg
module dvr_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [dvr_pkg::IDX_W-1:0] idx,
	input  dvr_pkg::route_t          route,
	input  dvr_pkg::ins_t            ins,
	input  dvr_pkg::tok_t            tok_in,
	output dvr_pkg::tok_t            tok_out
);
	import dvr_pkg::*;

	logic              valid_q;
	logic [ADDR_W-1:0] dest_q;
	logic [ADDR_W-1:0] hop_q;
	logic [ADDR_W-1:0] intf_q;
	logic [COST_W-1:0] cost_q;

	logic hit;
	logic better;
	logic upd;
	logic wr_new;
	tok_t nxt;

	assign hit    = valid_q && (dest_q == route.dest);
	assign better = route.cand < cost_q;
	assign wr_new = ins.en && (ins.slot == idx);

	always_comb begin
		nxt = tok_in;
		upd = 1'b0;
		if (tok_in.active && !tok_in.found) begin
			if (hit) begin
				nxt.found = 1'b1;
				nxt.slot  = idx;
				if (better) begin
					nxt.status = ST_IMPROVED;
					nxt.cost   = route.cand;
					nxt.hop    = route.next_hop;
					upd        = 1'b1;
				end else begin
					nxt.status = ST_KEPT;
					nxt.cost   = cost_q;
					nxt.hop    = hop_q;
				end
			end else if (!valid_q && !tok_in.have_free) begin
				nxt.have_free = 1'b1;
				nxt.free_slot = idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_out <= nxt;
			if (wr_new) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			cost_q <= route.cand;
			hop_q  <= route.next_hop;
			intf_q <= route.intf;
		end else if (wr_new) begin
			dest_q <= route.dest;
			cost_q <= route.cand;
			hop_q  <= route.next_hop;
			intf_q <= route.intf;
		end
	end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// testbench for distance_vector_route_update: keeps its own copy of the routing
// table, predicts every result as requests are accepted, checks them field by field
// depends on dvr_pkg and distance_vector_route_update
module tb;
	import dvr_pkg::*;

	localparam int IDLE_PCT   = 28;
	localparam int WDOG_LIMIT = 4000;
	localparam int RAND_ITEMS = 1080;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	logic req_stall;
	logic rsp_valid;
	req_t req       = '0;
	rsp_t rsp;

	logic              tbl_valid [TABLE_SIZE];
	logic [ADDR_W-1:0] tbl_dest  [TABLE_SIZE];
	logic [ADDR_W-1:0] tbl_hop   [TABLE_SIZE];
	logic [ADDR_W-1:0] tbl_ifc   [TABLE_SIZE];
	logic [COST_W-1:0] tbl_cost  [TABLE_SIZE];

	rsp_t pending_routes[$];
	int   errors      = 0;
	int   quiet_cycles = 0;
	bit   no_idle     = 1'b0;

	distance_vector_route_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < TABLE_SIZE; i++) begin
			tbl_valid[i] = 1'b0;
		end
	end

	// bellman-ford relaxation of one advertised entry against the table
	function automatic rsp_t update_route(req_t r);
		rsp_t              res;
		logic [COST_W-1:0] cand;
		int                free_idx;
		res = '0;
		free_idx = -1;
		if (r.neighbor_addr == r.advertised_dest) begin
			cand = COST_ONE;
		end else if (r.advertised_cost == COST_MAX) begin
			cand = COST_MAX;
		end else begin
			cand = r.advertised_cost + 1'b1;
		end
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (tbl_valid[i] && tbl_dest[i] == r.advertised_dest) begin
				res.slot = SLOT_W'(i);
				if (cand < tbl_cost[i]) begin
					tbl_cost[i] = cand;
					tbl_hop[i]  = r.neighbor_addr;
					tbl_ifc[i]  = r.receive_interface;
					res.status  = ST_IMPROVED;
				end else begin
					res.status = ST_KEPT;
				end
				res.stored_cost     = tbl_cost[i];
				res.stored_next_hop = tbl_hop[i];
				return res;
			end
			if (!tbl_valid[i] && free_idx < 0) begin
				free_idx = i;
			end
		end
		if (free_idx < 0) begin
			res.status = ST_FULL;
			return res;
		end
		tbl_valid[free_idx] = 1'b1;
		tbl_dest[free_idx]  = r.advertised_dest;
		tbl_hop[free_idx]   = r.neighbor_addr;
		tbl_ifc[free_idx]   = r.receive_interface;
		tbl_cost[free_idx]  = cand;
		res.status          = ST_INSERTED;
		res.slot            = SLOT_W'(free_idx);
		res.stored_cost     = cand;
		res.stored_next_hop = r.neighbor_addr;
		return res;
	endfunction

	task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
			logic [ADDR_W-1:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
	endtask

	task automatic send_req(input req_t r, output rsp_t predicted);
		if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		predicted = update_route(r);
		pending_routes = {pending_routes, predicted};
	endtask

	task automatic send_route(logic [ADDR_W-1:0] nbr, logic [ADDR_W-1:0] ifc,
			logic [ADDR_W-1:0] dst, logic [COST_W-1:0] cost);
		req_t r;
		rsp_t p;
		r.neighbor_addr     = nbr;
		r.receive_interface = ifc;
		r.advertised_dest   = dst;
		r.advertised_cost   = cost;
		send_req(r, p);
	endtask

	task automatic test_extremes();
		send_route('0, '0, '0, '0);
		send_route('1, '1, '1, '1);
		send_route(32'h0A00_0001, 32'hC0A8_0001, 32'h0A00_0002, 8'h00);
		send_route('1, 32'h5555_5555, '0, '0);
	endtask

	task automatic test_saturation();
		send_route(32'h0A00_0001, 32'hC0A8_0001, 32'h0B00_0000, 8'hFF);
		send_route(32'h0A00_0001, 32'hC0A8_0001, 32'h0C00_0000, 8'hFE);
		send_route(32'h0A00_0003, 32'hC0A8_0003, 32'h0B00_0000, 8'hFF);
	endtask

	task automatic test_equal_and_worse();
		send_route(32'h0A00_0001, 32'hC0A8_0001, 32'h0D00_0000, 8'd9);
		send_route(32'h0A00_0004, 32'hC0A8_0004, 32'h0D00_0000, 8'd9);
		send_route(32'h0A00_0004, 32'hC0A8_0004, 32'h0D00_0000, 8'd50);
	endtask

	task automatic test_improve();
		send_route(32'h0A00_0005, 32'hC0A8_0005, 32'h0D00_0000, 8'd3);
		send_route(32'h0A00_0006, 32'hC0A8_0006, 32'h0B00_0000, 8'h7F);
		send_route(32'h0D00_0000, 32'hC0A8_0007, 32'h0D00_0000, 8'hFF);
		send_route(32'h5555_5555, 32'hAAAA_AAAA, 32'h0C00_0000, 8'h00);
		send_route(32'hAAAA_AAAA, 32'h5555_5555, 32'h0C00_0000, 8'h00);
	endtask

	// mostly re-advertised known destinations, the rest new ones that fill the table
	task automatic test_random(int n);
		req_t r;
		rsp_t p;
		int   k;
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= 400 && i < 600);
			r.neighbor_addr     = $urandom;
			r.receive_interface = $urandom;
			k = $urandom_range(TABLE_SIZE - 1);
			if ($urandom_range(99) < 70 && tbl_valid[k]) begin
				r.advertised_dest = tbl_dest[k];
			end else begin
				r.advertised_dest = $urandom;
			end
			case ($urandom_range(9))
				0: begin
					r.advertised_cost = 8'h00;
				end
				1: begin
					r.advertised_cost = 8'hFF;
				end
				2: begin
					r.advertised_cost = 8'hFE;
				end
				3, 4, 5: begin
					r.advertised_cost = COST_W'($urandom_range(15));
				end
				default: begin
					r.advertised_cost = COST_W'($urandom);
				end
			endcase
			if ($urandom_range(9) == 0) begin
				r.neighbor_addr = r.advertised_dest;
			end
			send_req(r, p);
		end
		no_idle = 1'b0;
	endtask

	task automatic test_table_full();
		req_t r;
		rsp_t p;
		int   fulls;
		fulls = 0;
		while (fulls < 3) begin
			r.neighbor_addr     = $urandom;
			r.receive_interface = $urandom;
			r.advertised_dest   = $urandom;
			r.advertised_cost   = COST_W'($urandom);
			send_req(r, p);
			if (p.status == ST_FULL) begin
				fulls++;
			end
		end
		send_route(32'h0A00_0009, 32'hC0A8_0009, tbl_dest[TABLE_SIZE-1], 8'h00);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_saturation();
		test_equal_and_worse();
		test_improve();
		test_random(RAND_ITEMS);
		test_table_full();
		req_valid <= 1'b0;
		while (pending_routes.size() != 0) @(posedge clk);
		repeat (TABLE_SIZE + 5) @(posedge clk);
		if (errors == 0) begin
			$display("** distance_vector_route_update: PASSED **");
		end else begin
			$display("** distance_vector_route_update: FAILED **");
		end
		$finish;
	end

	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_routes.size() == 0) begin
				report_mismatch("result with no request pending", rsp.stored_next_hop, '0);
			end else begin
				want = pending_routes.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", ADDR_W'(rsp.status), ADDR_W'(want.status));
				if (rsp.slot !== want.slot)
					report_mismatch("slot", ADDR_W'(rsp.slot), ADDR_W'(want.slot));
				if (rsp.stored_cost !== want.stored_cost)
					report_mismatch("stored_cost", ADDR_W'(rsp.stored_cost),
						ADDR_W'(want.stored_cost));
				if (rsp.stored_next_hop !== want.stored_next_hop)
					report_mismatch("stored_next_hop", rsp.stored_next_hop,
						want.stored_next_hop);
			end
		end
		rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WDOG_LIMIT) begin
			$display("** distance_vector_route_update: FAILED **");
			$finish;
		end
	end

endmodule

@@ filelist.f @@
src/dvr_pkg.sv
src/dvr_cell.sv
src/distance_vector_route_update.sv
dv/tb.sv
